// File: rtl/core/ale_pkg.sv
package ale_pkg;

    // Field widths of the request and result beats
    localparam int ACTION_W    = 3;
    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 5;
    localparam int OUT_TDATA_W = 16;

    // Request action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR     = 3'd0,
        ACT_INS_HEAD  = 3'd1,
        ACT_INS_SORT  = 3'd2,
        ACT_SEARCH    = 3'd3,
        ACT_DEL_FIRST = 3'd4,
        ACT_DEL_ALL   = 3'd5
    } t_action;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN_UP,
        ST_SCAN_DN,
        ST_INS_LAST,
        ST_RESP
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic latch;      // capture request beat
        logic clear;      // empty the list
        logic refuse;     // insert into full list
        logic ins_first;  // insert into empty list
        logic start_up;   // arm upward scan
        logic run_up;     // upward scan step
        logic start_dn;   // arm downward shift
        logic run_dn;     // downward shift step
        logic ins_last;   // place value at the head slot
        logic load_out;   // load result register
    } t_ctl_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic [ACTION_W-1:0] act;
        logic                full;
        logic                empty;
        logic                up_done;
        logic                dn_place;
        logic                dn_bottom;
        logic                out_free;
    } t_dp_status;

endpackage

// File: rtl/core/ale_ram.sv
module ale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/ale_ctrl.sv
module ale_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  ale_pkg::t_dp_status   i_status,
    output ale_pkg::t_ctl_cmd     o_cmd
);

    ale_pkg::t_state r_state;
    ale_pkg::t_state n_state;
    logic            accept;

    assign o_s_tready = (r_state == ale_pkg::ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ale_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ale_pkg::ST_IDLE: begin
                if (accept) n_state = ale_pkg::ST_START;
            end
            ale_pkg::ST_START: begin
                case (i_status.act)
                    ale_pkg::ACT_INS_HEAD, ale_pkg::ACT_INS_SORT: begin
                        if (i_status.full || i_status.empty) n_state = ale_pkg::ST_RESP;
                        else                                 n_state = ale_pkg::ST_SCAN_DN;
                    end
                    ale_pkg::ACT_SEARCH, ale_pkg::ACT_DEL_FIRST, ale_pkg::ACT_DEL_ALL: begin
                        n_state = ale_pkg::ST_SCAN_UP;
                    end
                    default: n_state = ale_pkg::ST_RESP;
                endcase
            end
            ale_pkg::ST_SCAN_UP: begin
                if (i_status.up_done) n_state = ale_pkg::ST_RESP;
            end
            ale_pkg::ST_SCAN_DN: begin
                if (i_status.dn_place)       n_state = ale_pkg::ST_RESP;
                else if (i_status.dn_bottom) n_state = ale_pkg::ST_INS_LAST;
            end
            ale_pkg::ST_INS_LAST: n_state = ale_pkg::ST_RESP;
            ale_pkg::ST_RESP: begin
                if (i_status.out_free) n_state = ale_pkg::ST_IDLE;
            end
            default: n_state = ale_pkg::ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd = '0;
        case (r_state)
            ale_pkg::ST_IDLE: o_cmd.latch = accept;
            ale_pkg::ST_START: begin
                case (i_status.act)
                    ale_pkg::ACT_CLEAR: o_cmd.clear = 1'b1;
                    ale_pkg::ACT_INS_HEAD, ale_pkg::ACT_INS_SORT: begin
                        if (i_status.full)       o_cmd.refuse    = 1'b1;
                        else if (i_status.empty) o_cmd.ins_first = 1'b1;
                        else                     o_cmd.start_dn  = 1'b1;
                    end
                    ale_pkg::ACT_SEARCH, ale_pkg::ACT_DEL_FIRST, ale_pkg::ACT_DEL_ALL: begin
                        o_cmd.start_up = 1'b1;
                    end
                    default: ;
                endcase
            end
            ale_pkg::ST_SCAN_UP:  o_cmd.run_up   = 1'b1;
            ale_pkg::ST_SCAN_DN:  o_cmd.run_dn   = 1'b1;
            ale_pkg::ST_INS_LAST: o_cmd.ins_last = 1'b1;
            ale_pkg::ST_RESP:     o_cmd.load_out = i_status.out_free;
            default: ;
        endcase
    end

    // A request beat always moves the machine out of idle
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ale_pkg::ST_START))
        else $error("accepted beat did not start processing");

    // Only one scan mode driven at a time
    a_one_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.run_up && o_cmd.run_dn))
        else $error("upward and downward scans both active");

endmodule

// File: rtl/core/ale_dp.sv
module ale_dp #(
    parameter int CAPACITY = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ale_pkg::t_ctl_cmd                  i_cmd,
    output ale_pkg::t_dp_status                o_status,
    input  logic [ale_pkg::ACTION_W-1:0]       i_action,
    input  logic signed [ale_pkg::VALUE_W-1:0] i_value,
    input  logic                               i_m_tready,
    output logic                               o_valid,
    output logic                               o_found,
    output logic                               o_refused,
    output logic [ale_pkg::COUNT_W-1:0]        o_count,
    output logic                               o_empty,
    output logic                               o_full
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    // Request and list control state
    logic [ale_pkg::ACTION_W-1:0]       r_act,      n_act;
    logic signed [ale_pkg::VALUE_W-1:0] r_value,    n_value;
    logic [CW-1:0]                      r_count,    n_count;
    logic [CW-1:0]                      r_rd_ptr,   n_rd_ptr;
    logic [CW-1:0]                      r_wr_ptr,   n_wr_ptr;
    logic                               r_rd_on,    n_rd_on;
    logic                               r_pend,     n_pend;
    logic [AW-1:0]                      r_pend_addr, n_pend_addr;
    logic                               r_found,    n_found;
    logic                               r_refused,  n_refused;
    logic                               r_hit,      n_hit;

    // Result register
    logic                               r_out_valid,   n_out_valid;
    logic                               r_out_found,   n_out_found;
    logic                               r_out_refused, n_out_refused;
    logic [CW-1:0]                      r_out_count,   n_out_count;

    // RAM port
    logic                               ram_we;
    logic [AW-1:0]                      ram_waddr;
    logic [ale_pkg::VALUE_W-1:0]        ram_wdata;
    logic [AW-1:0]                      ram_raddr;
    logic [ale_pkg::VALUE_W-1:0]        ram_rdata;

    logic                               shift;
    logic                               match;
    logic                               keep;
    logic                               rd_more_up;
    logic [CW+ale_pkg::COUNT_W-1:0]     cnt_ext;

    ale_ram #(
        .WIDTH (ale_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Compares on the entry coming out of the RAM
    assign shift      = (r_act == ale_pkg::ACT_INS_HEAD) || ($signed(ram_rdata) > r_value);
    assign match      = (ram_rdata == r_value);
    assign rd_more_up = (r_rd_ptr < r_count);

    // Datapath next state
    always_comb begin
        n_act         = r_act;
        n_value       = r_value;
        n_count       = r_count;
        n_rd_ptr      = r_rd_ptr;
        n_wr_ptr      = r_wr_ptr;
        n_rd_on       = r_rd_on;
        n_pend        = r_pend;
        n_pend_addr   = r_pend_addr;
        n_found       = r_found;
        n_refused     = r_refused;
        n_hit         = r_hit;
        n_out_valid   = r_out_valid;
        n_out_found   = r_out_found;
        n_out_refused = r_out_refused;
        n_out_count   = r_out_count;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = r_value;
        ram_raddr     = '0;
        keep          = 1'b1;

        if (i_cmd.latch) begin
            n_act     = i_action;
            n_value   = i_value;
            n_found   = 1'b0;
            n_refused = 1'b0;
            n_hit     = 1'b0;
        end

        if (i_cmd.clear)  n_count   = '0;
        if (i_cmd.refuse) n_refused = 1'b1;

        // Insert into an empty list, or at the bottom of a downward shift, goes straight to the head slot
        if (i_cmd.ins_first || i_cmd.ins_last) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = r_value;
            n_count   = r_count + 1'b1;
        end

        // Upward scan: read at rd_ptr, compact kept entries down to wr_ptr (a search writes nothing)
        if (i_cmd.start_up) begin
            n_rd_ptr = '0;
            n_wr_ptr = '0;
            n_pend   = 1'b0;
        end
        if (i_cmd.run_up) begin
            if (rd_more_up) begin
                ram_raddr   = r_rd_ptr[AW-1:0];
                n_rd_ptr    = r_rd_ptr + 1'b1;
                n_pend      = 1'b1;
                n_pend_addr = r_rd_ptr[AW-1:0];
            end else begin
                n_pend = 1'b0;
            end
            if (r_pend) begin
                case (r_act)
                    ale_pkg::ACT_SEARCH: begin
                        if (match) n_found = 1'b1;
                    end
                    ale_pkg::ACT_DEL_FIRST: begin
                        keep = !(match && !r_hit);
                        if (match) n_hit = 1'b1;
                    end
                    ale_pkg::ACT_DEL_ALL: keep = !match;
                    default: ;
                endcase
                if (keep) begin
                    n_wr_ptr  = r_wr_ptr + 1'b1;
                    ram_we    = (r_act != ale_pkg::ACT_SEARCH);
                    ram_waddr = r_wr_ptr[AW-1:0];
                    ram_wdata = ram_rdata;
                end
            end else if (!rd_more_up) begin
                n_count = r_wr_ptr;
            end
        end

        // Downward shift: move entries up one slot until the value fits
        if (i_cmd.start_dn) begin
            n_rd_ptr = r_count - 1'b1;
            n_rd_on  = 1'b1;
            n_pend   = 1'b0;
        end
        if (i_cmd.run_dn) begin
            if (r_rd_on) begin
                ram_raddr   = r_rd_ptr[AW-1:0];
                n_pend      = 1'b1;
                n_pend_addr = r_rd_ptr[AW-1:0];
                if (r_rd_ptr == '0) n_rd_on = 1'b0;
                else                n_rd_ptr = r_rd_ptr - 1'b1;
            end else begin
                n_pend = 1'b0;
            end
            if (r_pend) begin
                ram_we    = 1'b1;
                ram_waddr = r_pend_addr + 1'b1;
                ram_wdata = shift ? ram_rdata : r_value;
                if (!shift) n_count = r_count + 1'b1;
            end
        end

        // Result register
        if (i_cmd.load_out) begin
            n_out_valid   = 1'b1;
            n_out_found   = r_found;
            n_out_refused = r_refused;
            n_out_count   = r_count;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rd_on     <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_rd_on     <= n_rd_on;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_act         <= n_act;
        r_value       <= n_value;
        r_rd_ptr      <= n_rd_ptr;
        r_wr_ptr      <= n_wr_ptr;
        r_pend_addr   <= n_pend_addr;
        r_found       <= n_found;
        r_refused     <= n_refused;
        r_hit         <= n_hit;
        r_out_found   <= n_out_found;
        r_out_refused <= n_out_refused;
        r_out_count   <= n_out_count;
    end

    // Status to controller
    assign o_status.act       = r_act;
    assign o_status.full      = (r_count >= CAP);
    assign o_status.empty     = (r_count == '0);
    assign o_status.up_done   = !r_pend && !rd_more_up;
    assign o_status.dn_place  = r_pend && !shift;
    assign o_status.dn_bottom = r_pend && shift && (r_pend_addr == '0);
    assign o_status.out_free  = !r_out_valid || i_m_tready;

    // Result fields
    assign cnt_ext   = (CW + ale_pkg::COUNT_W)'(r_out_count);
    assign o_valid   = r_out_valid;
    assign o_found   = r_out_found;
    assign o_refused = r_out_refused;
    assign o_count   = cnt_ext[ale_pkg::COUNT_W-1:0];
    assign o_empty   = (r_out_count == '0);
    assign o_full    = (r_out_count == CAP);

    // Count never passes capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP)
        else $error("entry count beyond capacity");

    // Compaction writes never overtake the read stream
    a_wr_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.run_up && r_pend) |-> (r_wr_ptr <= CW'(r_pend_addr)))
        else $error("compaction write ahead of read");

endmodule

// File: rtl/core/array_list_engine_core.sv
// A clear, a refused insert, an insert into an empty list or an unknown action goes from
// start straight to the result; search, deletes and other inserts scan the list first.
// One request at a time; the next is taken once the previous result is in the output
// register, and a scan is paced by the single read port of the entry RAM stepping one
// entry per cycle.
// Reset (synchronous, active low) empties the list; entry contents are not cleared.
module array_list_engine_core #(
    parameter int CAPACITY = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [ale_pkg::VALUE_W-1:0]         i_s_tdata,  // [31:0] value
    input  logic [ale_pkg::ACTION_W-1:0]        i_s_tuser,  // [2:0] action
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [ale_pkg::OUT_TDATA_W-1:0]     o_m_tdata   // [0] found, [1] status,
                                                            // [6:2] count, [7] is_empty,
                                                            // [8] is_full, [15:9] zero
);

    ale_pkg::t_ctl_cmd            cmd;
    ale_pkg::t_dp_status          status;
    logic                         found;
    logic                         refused;
    logic [ale_pkg::COUNT_W-1:0]  count;
    logic                         is_empty;
    logic                         is_full;

    ale_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ale_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_action   (i_s_tuser),
        .i_value    ($signed(i_s_tdata)),
        .i_m_tready (i_m_tready),
        .o_valid    (o_m_tvalid),
        .o_found    (found),
        .o_refused  (refused),
        .o_count    (count),
        .o_empty    (is_empty),
        .o_full     (is_full)
    );

    // Pack result beat
    assign o_m_tdata = {7'b0, is_full, is_empty, count, refused, found};

    // A refused insert is only ever reported against a full list
    a_refused_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && refused) |-> is_full)
        else $error("refused insert reported with list not full");

endmodule

// File: tb/tb_array_list_engine_core.sv
module tb_array_list_engine_core;

    localparam int LIST_CAP   = 16;
    localparam int N_REQ      = 1850;
    localparam int HOLD_CYC   = 300;
    localparam int DRAIN_CYC  = LIST_CAP + 8;
    localparam int MAX_REPORT = 10;

    // Action codes the block ignores
    localparam logic [ale_pkg::ACTION_W-1:0] ACT_RSVD_6 = 3'd6;
    localparam logic [ale_pkg::ACTION_W-1:0] ACT_RSVD_7 = 3'd7;

    localparam logic [ale_pkg::VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [ale_pkg::VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [ale_pkg::VALUE_W-1:0] VAL_M1  = 32'hFFFF_FFFF;

    // Request beat and result beat, result laid out as o_m_tdata
    typedef struct packed {
        logic [ale_pkg::ACTION_W-1:0]       action;
        logic signed [ale_pkg::VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [6:0]                  pad;
        logic                        full;
        logic                        empty;
        logic [ale_pkg::COUNT_W-1:0] count;
        logic                        status;
        logic                        found;
    } t_rsp;

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    logic [ale_pkg::VALUE_W-1:0]     i_s_tdata  = '0;   // [31:0] value
    logic [ale_pkg::ACTION_W-1:0]    i_s_tuser  = '0;   // [2:0] action
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    logic [ale_pkg::OUT_TDATA_W-1:0] o_m_tdata;         // [0] found, [1] status, [6:2] count,
                                                        // [7] is_empty, [8] is_full, [15:9] zero

    array_list_engine_core #(
        .CAPACITY (LIST_CAP)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Shadow of the list
    logic signed [ale_pkg::VALUE_W-1:0] list_vals [LIST_CAP];
    int                                 list_len = 0;

    t_req req_backlog [$];
    t_rsp rsp_expected [$];

    int   n_req_taken = 0;
    int   n_mismatch  = 0;
    logic s_fire      = 1'b0;
    logic m_fire      = 1'b0;
    int   s_wait      = 0;
    int   m_wait      = 0;
    logic s_burst     = 1'b0;
    logic m_burst     = 1'b0;
    logic m_hold      = 1'b0;
    t_req s_next;
    t_req taken;
    t_rsp got;
    t_rsp want;

    always #6 i_clk = ~i_clk;

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Apply one request to the shadow list and return its result
    function automatic t_rsp list_apply(t_req r);
        t_rsp                               res;
        logic signed [ale_pkg::VALUE_W-1:0] v;
        int                                 i;
        int                                 j;
        res = '0;
        v   = r.value;
        case (r.action)
            ale_pkg::ACT_CLEAR: begin
                list_len = 0;
            end
            ale_pkg::ACT_INS_HEAD: begin
                if (list_len >= LIST_CAP) begin
                    res.status = 1'b1;
                end else begin
                    for (i = list_len; i > 0; i--)
                        list_vals[i] = list_vals[i-1];
                    list_vals[0] = v;
                    list_len++;
                end
            end
            ale_pkg::ACT_INS_SORT: begin
                if (list_len >= LIST_CAP) begin
                    res.status = 1'b1;
                end else begin
                    // goes after the last entry not greater than v
                    i = list_len;
                    while (i > 0 && list_vals[i-1] > v) begin
                        list_vals[i] = list_vals[i-1];
                        i--;
                    end
                    list_vals[i] = v;
                    list_len++;
                end
            end
            ale_pkg::ACT_SEARCH: begin
                for (i = 0; i < list_len; i++)
                    if (list_vals[i] == v)
                        res.found = 1'b1;
            end
            ale_pkg::ACT_DEL_FIRST: begin
                j = -1;
                for (i = 0; i < list_len; i++)
                    if (j < 0 && list_vals[i] == v)
                        j = i;
                if (j >= 0) begin
                    for (i = j; i + 1 < list_len; i++)
                        list_vals[i] = list_vals[i+1];
                    list_len--;
                end
            end
            ale_pkg::ACT_DEL_ALL: begin
                j = 0;
                for (i = 0; i < list_len; i++) begin
                    if (list_vals[i] != v) begin
                        list_vals[j] = list_vals[i];
                        j++;
                    end
                end
                list_len = j;
            end
            default: begin
            end
        endcase
        res.count = ale_pkg::COUNT_W'(list_len);
        res.empty = (list_len == 0);
        res.full  = (list_len == LIST_CAP);
        return res;
    endfunction

    task automatic queue_req(logic [ale_pkg::ACTION_W-1:0] act,
                             logic [ale_pkg::VALUE_W-1:0] val);
        t_req r;
        r.action = act;
        r.value  = val;
        req_backlog.push_back(r);
    endtask

    // Value for a sequence: mostly from a small pool so searches and deletes hit
    function automatic logic [ale_pkg::VALUE_W-1:0] pool_val(
        logic [ale_pkg::VALUE_W-1:0] pool [6]);
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return pool[$urandom_range(0, 5)];
    endfunction

    // Stimulus, then drain and final verdict
    initial begin
        logic [ale_pkg::VALUE_W-1:0]  pool [6];
        logic [ale_pkg::ACTION_W-1:0] act;
        int                           kind;
        int                           n;
        int                           k;
        int                           pick;

        // directed: empty list, ignored codes, extremes, ordering, full list
        queue_req(ale_pkg::ACT_SEARCH, '0);
        queue_req(ale_pkg::ACT_DEL_ALL, '0);
        queue_req(ACT_RSVD_6, VAL_M1);
        queue_req(ACT_RSVD_7, '0);
        queue_req(ale_pkg::ACT_INS_SORT, VAL_MAX);
        queue_req(ale_pkg::ACT_INS_SORT, VAL_MIN);
        queue_req(ale_pkg::ACT_INS_SORT, '0);
        queue_req(ale_pkg::ACT_INS_SORT, '0);
        queue_req(ale_pkg::ACT_INS_SORT, VAL_M1);
        queue_req(ale_pkg::ACT_INS_HEAD, 32'd5);
        queue_req(ale_pkg::ACT_SEARCH, VAL_MIN);
        queue_req(ale_pkg::ACT_DEL_FIRST, '0);
        queue_req(ale_pkg::ACT_DEL_ALL, 32'd5);
        for (k = 0; k < LIST_CAP - 4; k++)
            queue_req((k % 2) ? ale_pkg::ACT_INS_HEAD : ale_pkg::ACT_INS_SORT,
                      32'hA5A5_0000 + k);
        queue_req(ale_pkg::ACT_INS_HEAD, 32'd1);
        queue_req(ale_pkg::ACT_INS_SORT, 32'd1);
        queue_req(ale_pkg::ACT_SEARCH, VAL_MAX);
        queue_req(ale_pkg::ACT_CLEAR, VAL_M1);

        // random sequences
        while (req_backlog.size() < N_REQ) begin
            for (k = 0; k < 6; k++) begin
                case ($urandom_range(0, 6))
                    0:       pool[k] = VAL_MIN;
                    1:       pool[k] = VAL_MAX;
                    2:       pool[k] = VAL_M1;
                    3, 4:    pool[k] = $urandom_range(0, 7) - 4;
                    default: pool[k] = $urandom;
                endcase
            end
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
                // fill up to or past capacity, then probe
                queue_req(ale_pkg::ACT_CLEAR, $urandom);
                n = $urandom_range(10, 20);
                for (k = 0; k < n; k++)
                    queue_req($urandom_range(0, 1) ? ale_pkg::ACT_INS_HEAD
                                                   : ale_pkg::ACT_INS_SORT,
                              pool_val(pool));
                n = $urandom_range(2, 8);
                for (k = 0; k < n; k++) begin
                    case ($urandom_range(0, 2))
                        0:       act = ale_pkg::ACT_SEARCH;
                        1:       act = ale_pkg::ACT_DEL_FIRST;
                        default: act = ale_pkg::ACT_DEL_ALL;
                    endcase
                    queue_req(act, pool_val(pool));
                end
            end else if (kind < 80) begin
                // mixed traffic on a shared pool
                n = $urandom_range(10, 40);
                for (k = 0; k < n; k++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 22)
                        act = ale_pkg::ACT_INS_HEAD;
                    else if (pick < 45)
                        act = ale_pkg::ACT_INS_SORT;
                    else if (pick < 65)
                        act = ale_pkg::ACT_SEARCH;
                    else if (pick < 80)
                        act = ale_pkg::ACT_DEL_FIRST;
                    else if (pick < 93)
                        act = ale_pkg::ACT_DEL_ALL;
                    else if (pick < 96)
                        act = ale_pkg::ACT_CLEAR;
                    else
                        act = $urandom_range(0, 1) ? ACT_RSVD_6 : ACT_RSVD_7;
                    queue_req(act, pool_val(pool));
                end
            end else begin
                // noise: any code, any value
                n = $urandom_range(3, 12);
                for (k = 0; k < n; k++)
                    queue_req(ale_pkg::ACTION_W'($urandom_range(0, 7)), $urandom);
            end
        end

        // drain
        @(posedge i_clk);
        while (req_backlog.size() != 0 || i_s_tvalid || rsp_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (n_mismatch == 0 && rsp_expected.size() == 0) begin
            $display("tb_array_list_engine_core passed");
        end else begin
            $display("tb_array_list_engine_core failed");
        end
        $finish;
    end

    initial begin
        #4_800_000;
        $display("tb_array_list_engine_core failed");
        $finish;
    end

    // Long receiver hold-off so the block backs up and stalls its input
    initial begin
        while (n_req_taken < 400) @(negedge i_clk);
        m_hold <= 1'b1;
        repeat (HOLD_CYC) @(negedge i_clk);
        m_hold <= 1'b0;
    end

    // Request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || s_fire) begin
            if (s_wait > 0) begin
                s_wait--;
                i_s_tvalid <= 1'b0;
            end else if (req_backlog.size() != 0) begin
                s_next = req_backlog.pop_front();
                i_s_tuser  <= s_next.action;
                i_s_tdata  <= s_next.value;
                i_s_tvalid <= 1'b1;
                s_wait = s_burst ? 0 : $urandom_range(0, 13);
                if ($urandom_range(0, 63) == 0)
                    s_burst = !s_burst;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver back-pressure
    always @(negedge i_clk) begin
        if (m_fire) begin
            m_wait = m_burst ? 0 : $urandom_range(0, 13);
            if ($urandom_range(0, 63) == 0)
                m_burst = !m_burst;
        end else if (m_wait > 0) begin
            m_wait--;
        end
        i_m_tready <= i_rst_n && !m_hold && (m_wait == 0);
    end

    // Monitor: predict on each request beat, check each result beat
    always @(posedge i_clk) begin
        s_fire <= i_s_tvalid && o_s_tready;
        m_fire <= o_m_tvalid && i_m_tready;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                taken.action = i_s_tuser;
                taken.value  = i_s_tdata;
                rsp_expected.push_back(list_apply(taken));
                n_req_taken++;
            end
            if (o_m_tvalid && i_m_tready) begin
                got = t_rsp'(o_m_tdata);
                if (rsp_expected.size() == 0) begin
                    if (n_mismatch < MAX_REPORT)
                        $display("%0t: result beat with none expected, tdata=%h",
                                 $realtime, o_m_tdata);
                    n_mismatch++;
                end else begin
                    want = rsp_expected.pop_front();
                    if (got !== want) begin
                        if (n_mismatch < MAX_REPORT) begin
                            $display("%0t: mismatch exp found=%b status=%b count=%0d empty=%b full=%b pad=%h",
                                     $realtime, want.found, want.status, want.count,
                                     want.empty, want.full, want.pad);
                            $display("%0t:          got found=%b status=%b count=%0d empty=%b full=%b pad=%h",
                                     $realtime, got.found, got.status, got.count,
                                     got.empty, got.full, got.pad);
                        end
                        n_mismatch++;
                    end
                end
            end
        end
    end

endmodule
